// ----- hdl/rfb_client_raw_stream_parser_unit_defines.svh -----
// assertion macros for the raw stream parser
`ifndef RFB_CLIENT_RAW_STREAM_PARSER_UNIT_DEFINES_SVH
`define RFB_CLIENT_RAW_STREAM_PARSER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RFB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RFB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RFB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/rfb_pkg.sv -----
`default_nettype none
package rfb_pkg;
   localparam int COORD_BITS = 12;
   localparam int SKIP_BITS  = 12;

   typedef enum logic [3:0] {
      PH_BANNER   = 4'd0,
      PH_SECURITY = 4'd1,
      PH_INIT     = 4'd2,
      PH_NAME     = 4'd3,
      PH_MSG      = 4'd4,
      PH_UPD_HDR  = 4'd5,
      PH_RECT_HDR = 4'd6,
      PH_PIXELS   = 4'd7,
      PH_CUT_HDR  = 4'd8,
      PH_CUT_TEXT = 4'd9,
      PH_CLOSED   = 4'd10
   } phase_type;

   localparam logic [2:0] KIND_PIXEL   = 3'd0;
   localparam logic [2:0] KIND_VERSION = 3'd1;
   localparam logic [2:0] KIND_INIT    = 3'd2;
   localparam logic [2:0] KIND_REQUEST = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   localparam logic [3:0] ERR_BANNER   = 4'd0;
   localparam logic [3:0] ERR_SECURITY = 4'd1;
   localparam logic [3:0] ERR_NAME     = 4'd2;
   localparam logic [3:0] ERR_BPP      = 4'd3;
   localparam logic [3:0] ERR_SIZE     = 4'd4;
   localparam logic [3:0] ERR_ZERO     = 4'd5;
   localparam logic [3:0] ERR_RECT     = 4'd6;
   localparam logic [3:0] ERR_MSGTYPE  = 4'd7;
   localparam logic [3:0] ERR_CUT      = 4'd8;
   localparam logic [3:0] ERR_LINK     = 4'd9;

   localparam logic [1:0] REG_MAX_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MAX_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MAX_NAME   = 2'd2;
   localparam logic [1:0] REG_MAX_CUT    = 2'd3;

   localparam logic [23:0] BANNER_RFB = 24'h524642;

   typedef struct packed {
      logic [2:0]             kind;
      logic [COORD_BITS-1:0]  pixel_x;
      logic [COORD_BITS-1:0]  pixel_row;
      logic [31:0]            pixel_rgba;
      logic                   req_incremental;
      logic [COORD_BITS-1:0]  req_width;
      logic [COORD_BITS-1:0]  req_height;
      logic [3:0]             error_code;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic [11:0] max_width;
      logic [11:0] max_height;
      logic [11:0] max_title_len;
      logic [11:0] max_cut_text;
   } limits_type;
endpackage
`default_nettype wire

// ----- hdl/rfb_csr.sv -----
`default_nettype none
module rfb_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output rfb_pkg::limits_type     limits
);
   rfb_pkg::limits_type regs_ff, regs_in;
   logic [1:0] idx;

   assign idx    = paddr[3:2];
   assign pready = 1'b1;
   assign limits = regs_ff;

   // register write
   always_comb begin
      regs_in = regs_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            rfb_pkg::REG_MAX_WIDTH:  regs_in.max_width     = pwdata[11:0];
            rfb_pkg::REG_MAX_HEIGHT: regs_in.max_height    = pwdata[11:0];
            rfb_pkg::REG_MAX_NAME:   regs_in.max_title_len = pwdata[11:0];
            rfb_pkg::REG_MAX_CUT:    regs_in.max_cut_text  = pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.max_width     <= 12'd1920;
         regs_ff.max_height    <= 12'd1080;
         regs_ff.max_title_len <= 12'd512;
         regs_ff.max_cut_text  <= 12'd2048;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // register read
   always_comb begin
      case (idx)
         rfb_pkg::REG_MAX_WIDTH:  prdata = {20'd0, regs_ff.max_width};
         rfb_pkg::REG_MAX_HEIGHT: prdata = {20'd0, regs_ff.max_height};
         rfb_pkg::REG_MAX_NAME:   prdata = {20'd0, regs_ff.max_title_len};
         rfb_pkg::REG_MAX_CUT:    prdata = {20'd0, regs_ff.max_cut_text};
         default:                 prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

// ----- hdl/rfb_pixel_dec.sv -----
`default_nettype none
module rfb_pixel_dec (
   input  wire logic        big_endian,
   input  wire logic [31:0] word,
   input  wire logic [15:0] max_r,
   input  wire logic [15:0] max_g,
   input  wire logic [15:0] max_b,
   input  wire logic [7:0]  shift_r,
   input  wire logic [7:0]  shift_g,
   input  wire logic [7:0]  shift_b,
   output logic [31:0]      rgba
);
   logic [31:0] raw, cr, cg, cb;

   // byte order of the server
   assign raw = big_endian ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};

   // shift and mask per channel, large shifts read zero
   assign cr = (shift_r >= 8'd32) ? 32'd0 : ((raw >> shift_r[4:0]) & {16'd0, max_r});
   assign cg = (shift_g >= 8'd32) ? 32'd0 : ((raw >> shift_g[4:0]) & {16'd0, max_g});
   assign cb = (shift_b >= 8'd32) ? 32'd0 : ((raw >> shift_b[4:0]) & {16'd0, max_b});

   assign rgba = 32'hff000000 | (cb << 16) | (cg << 8) | cr;
endmodule
`default_nettype wire

// ----- hdl/rfb_client_raw_stream_parser_unit.sv -----
// Raw stream parser for an RFB 3.3 client. One byte (or a link-closed event) is taken per
// transfer: items enter an input register, one pass of parser logic updates the session state and
// writes up to two results into a two-entry output queue. Input stall rises only when the queue
// may not hold the next item's results, so a byte per cycle is sustained while the result side
// keeps up. Each pixel of a raw rect costs four bytes; the last pixel of the last rect also gives
// an incremental update request.
`default_nettype none
`include "rfb_client_raw_stream_parser_unit_defines.svh"
module rfb_client_raw_stream_parser_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic [7:0]                       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [2:0]                            rsp_kind,
   output logic [rfb_pkg::COORD_BITS-1:0]        rsp_pixel_x,
   output logic [rfb_pkg::COORD_BITS-1:0]        rsp_pixel_row,
   output logic [31:0]                           rsp_pixel_rgba,
   output logic                                  rsp_req_incremental,
   output logic [rfb_pkg::COORD_BITS-1:0]        rsp_req_width,
   output logic [rfb_pkg::COORD_BITS-1:0]        rsp_req_height,
   output logic [3:0]                            rsp_error_code,
   output logic                                  rsp_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [3:0]                       csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   localparam int CB = rfb_pkg::COORD_BITS;
   localparam int SB = rfb_pkg::SKIP_BITS;

   rfb_pkg::limits_type limits;

   rfb_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .limits(limits)
   );

   // input register
   logic       in_vld_ff;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       req_take;

   // result queue
   rfb_pkg::result_type q_ff [2];
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       q_rd_ff;
   logic       pop;

   // session state
   rfb_pkg::phase_type phase_ff, phase_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [31:0]  sr_ff, sr_in;
   logic [SB-1:0] skip_ff, skip_in;
   logic [CB-1:0] sw_ff, sw_in, sh_ff, sh_in;
   logic         be_ff, be_in;
   logic [15:0]  cmax_ff [3];
   logic [15:0]  cmax_in [3];
   logic [7:0]   csh_ff [3];
   logic [7:0]   csh_in [3];
   logic [15:0]  rects_ff, rects_in;
   logic [15:0]  box_ff [4];
   logic [15:0]  box_in [4];
   logic [CB-1:0] col_ff, col_in, line_ff, line_in;
   logic [23:0]  pb_ff, pb_in;

   logic [31:0]  rgba;
   rfb_pkg::result_type r0, r1;
   logic [1:0]   nres;

   // an item in the input register may produce two results; hold off unless room stays
   assign req_stall = in_vld_ff && (q_cnt_ff != 2'd0) && !(q_cnt_ff == 2'd1 && pop);
   assign req_take  = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   rfb_pixel_dec u_dec (
      .big_endian(be_ff), .word(sr_in),
      .max_r(cmax_ff[0]), .max_g(cmax_ff[1]), .max_b(cmax_ff[2]),
      .shift_r(csh_ff[0]), .shift_g(csh_ff[1]), .shift_b(csh_ff[2]),
      .rgba(rgba)
   );

   // parser step
   always_comb begin
      logic [4:0]  c;
      logic [7:0]  b;
      logic [16:0] sx, sy;
      logic [CB-1:0] ypos, coln, linen;
      rfb_pkg::result_type rq, er;
      logic        do_req, do_fail, do_fin;
      logic [3:0]  ecode;
      logic        inc;

      c = cnt_ff;
      b = in_byte_ff;
      phase_in = phase_ff; cnt_in = cnt_ff; sr_in = sr_ff; skip_in = skip_ff;
      sw_in = sw_ff; sh_in = sh_ff; be_in = be_ff;
      cmax_in = cmax_ff; csh_in = csh_ff; rects_in = rects_ff; box_in = box_ff;
      col_in = col_ff; line_in = line_ff; pb_in = pb_ff;
      r0 = '0; r1 = '0; nres = 2'd0; rq = '0; er = '0;
      do_req = 1'b0; do_fail = 1'b0; do_fin = 1'b0; ecode = '0; inc = 1'b0;
      sx = '0; sy = '0; ypos = '0; coln = '0; linen = '0;

      if (in_vld_ff && phase_ff != rfb_pkg::PH_CLOSED) begin
         if (in_cmd_ff) begin
            do_fail = 1'b1; ecode = rfb_pkg::ERR_LINK;
         end else begin
            sr_in  = {sr_ff[23:0], b};
            cnt_in = c + 5'd1;
            case (phase_ff)
               rfb_pkg::PH_BANNER: begin
                  if (c == 5'd11) begin
                     cnt_in = '0;
                     if (pb_ff != rfb_pkg::BANNER_RFB) begin
                        do_fail = 1'b1; ecode = rfb_pkg::ERR_BANNER;
                     end else begin
                        r0.kind = rfb_pkg::KIND_VERSION; nres = 2'd1;
                        phase_in = rfb_pkg::PH_SECURITY;
                     end
                  end else if (c < 5'd3) begin
                     pb_in = {pb_ff[15:0], b};
                  end
               end
               rfb_pkg::PH_SECURITY: begin
                  if (c == 5'd3) begin
                     cnt_in = '0;
                     if (sr_in != 32'd1) begin
                        do_fail = 1'b1; ecode = rfb_pkg::ERR_SECURITY;
                     end else begin
                        r0.kind = rfb_pkg::KIND_INIT; nres = 2'd1;
                        phase_in = rfb_pkg::PH_INIT;
                     end
                  end
               end
               rfb_pkg::PH_INIT: begin
                  case (c)
                     5'd1:  box_in[0] = sr_in[15:0];
                     5'd3:  box_in[1] = sr_in[15:0];
                     5'd4:  pb_in = {16'd0, b};
                     5'd6:  be_in = (b != 8'd0);
                     5'd9:  cmax_in[0] = sr_in[15:0];
                     5'd11: cmax_in[1] = sr_in[15:0];
                     5'd13: cmax_in[2] = sr_in[15:0];
                     5'd14: csh_in[0] = b;
                     5'd15: csh_in[1] = b;
                     5'd16: csh_in[2] = b;
                     5'd23: begin
                        cnt_in = '0;
                        if (sr_in > {20'd0, limits.max_title_len}) begin
                           do_fail = 1'b1; ecode = rfb_pkg::ERR_NAME;
                        end else if (pb_ff != 24'd32) begin
                           do_fail = 1'b1; ecode = rfb_pkg::ERR_BPP;
                        end else if (box_ff[0] > {4'd0, limits.max_width} ||
                                     box_ff[1] > {4'd0, limits.max_height}) begin
                           do_fail = 1'b1; ecode = rfb_pkg::ERR_SIZE;
                        end else begin
                           sw_in = box_ff[0][CB-1:0];
                           sh_in = box_ff[1][CB-1:0];
                           skip_in = sr_in[SB-1:0];
                           if (sr_in[SB-1:0] == '0) do_req = 1'b1;
                           else phase_in = rfb_pkg::PH_NAME;
                        end
                     end
                     default: ;
                  endcase
               end
               rfb_pkg::PH_NAME, rfb_pkg::PH_CUT_TEXT: begin
                  cnt_in = '0;
                  skip_in = skip_ff - 1'b1;
                  if (skip_in == '0) begin
                     if (phase_ff == rfb_pkg::PH_NAME) do_req = 1'b1;
                     else phase_in = rfb_pkg::PH_MSG;
                  end
               end
               rfb_pkg::PH_MSG: begin
                  cnt_in = '0;
                  if (b == 8'd0) phase_in = rfb_pkg::PH_UPD_HDR;
                  else if (b == 8'd3) phase_in = rfb_pkg::PH_CUT_HDR;
                  else if (b != 8'd2) begin
                     do_fail = 1'b1; ecode = rfb_pkg::ERR_MSGTYPE;
                  end
               end
               rfb_pkg::PH_UPD_HDR: begin
                  if (c == 5'd2) begin
                     cnt_in = '0;
                     rects_in = sr_in[15:0];
                     if (sr_in[15:0] == 16'd0) begin
                        do_fail = 1'b1; ecode = rfb_pkg::ERR_ZERO;
                     end else phase_in = rfb_pkg::PH_RECT_HDR;
                  end
               end
               rfb_pkg::PH_CUT_HDR: begin
                  if (c == 5'd6) begin
                     cnt_in = '0;
                     if (sr_in > {20'd0, limits.max_cut_text}) begin
                        do_fail = 1'b1; ecode = rfb_pkg::ERR_CUT;
                     end else begin
                        skip_in = sr_in[SB-1:0];
                        phase_in = (sr_in[SB-1:0] == '0) ? rfb_pkg::PH_MSG
                                                         : rfb_pkg::PH_CUT_TEXT;
                     end
                  end
               end
               rfb_pkg::PH_RECT_HDR: begin
                  if (c == 5'd1 || c == 5'd3 || c == 5'd5 || c == 5'd7) begin
                     box_in[c[2:1]] = sr_in[15:0];
                  end else if (c == 5'd11) begin
                     cnt_in = '0;
                     sx = {1'b0, box_ff[0]} + {1'b0, box_ff[2]};
                     sy = {1'b0, box_ff[1]} + {1'b0, box_ff[3]};
                     if (sx > {{(17-CB){1'b0}}, sw_ff} || sy > {{(17-CB){1'b0}}, sh_ff}) begin
                        do_fail = 1'b1; ecode = rfb_pkg::ERR_RECT;
                     end else begin
                        col_in = '0; line_in = '0;
                        if (box_ff[2] == 16'd0 || box_ff[3] == 16'd0) do_fin = 1'b1;
                        else phase_in = rfb_pkg::PH_PIXELS;
                     end
                  end
               end
               rfb_pkg::PH_PIXELS: begin
                  if (c == 5'd3) begin
                     cnt_in = '0;
                     ypos = box_ff[1][CB-1:0] + line_ff;
                     r0.kind = rfb_pkg::KIND_PIXEL;
                     r0.pixel_x = box_ff[0][CB-1:0] + col_ff;
                     r0.pixel_row = sh_ff - 1'b1 - ypos;
                     r0.pixel_rgba = rgba;
                     nres = 2'd1;
                     coln = col_ff + 1'b1;
                     col_in = coln;
                     if ({{(16-CB){1'b0}}, coln} >= box_ff[2]) begin
                        col_in = '0;
                        linen = line_ff + 1'b1;
                        line_in = linen;
                        if ({{(16-CB){1'b0}}, linen} >= box_ff[3]) do_fin = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end

         // rect completion
         if (do_fin) begin
            rects_in = rects_ff - 16'd1;
            if (rects_in == 16'd0) begin
               do_req = 1'b1; inc = 1'b1;
            end else phase_in = rfb_pkg::PH_RECT_HDR;
         end

         // request and error results
         rq.kind = rfb_pkg::KIND_REQUEST;
         rq.req_incremental = inc;
         rq.req_width = sw_in;
         rq.req_height = sh_in;
         er.kind = rfb_pkg::KIND_ERROR;
         er.error_code = ecode;
         if (do_fail) begin
            phase_in = rfb_pkg::PH_CLOSED;
            r0 = er; nres = 2'd1;
         end else if (do_req) begin
            phase_in = rfb_pkg::PH_MSG;
            if (nres == 2'd1) begin
               r1 = rq; nres = 2'd2;
            end else begin
               r0 = rq; nres = 2'd1;
            end
         end
         if (nres == 2'd1) r0.last = 1'b1;
         if (nres == 2'd2) r1.last = 1'b1;
      end
   end

   // input register and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff <= rfb_pkg::PH_BANNER;
         cnt_ff <= '0; sr_ff <= '0; skip_ff <= '0; sw_ff <= '0; sh_ff <= '0;
         be_ff <= 1'b0; rects_ff <= '0; col_ff <= '0; line_ff <= '0; pb_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            cmax_ff[i] <= '0; csh_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) box_ff[i] <= '0;
      end else begin
         if (!req_stall) begin
            in_vld_ff <= req_take;
            in_cmd_ff <= req_cmd;
            in_byte_ff <= req_rx_byte;
         end
         if (!req_stall) begin
            phase_ff <= phase_in; cnt_ff <= cnt_in; sr_ff <= sr_in; skip_ff <= skip_in;
            sw_ff <= sw_in; sh_ff <= sh_in; be_ff <= be_in; rects_ff <= rects_in;
            col_ff <= col_in; line_ff <= line_in; pb_ff <= pb_in;
            cmax_ff <= cmax_in; csh_ff <= csh_in; box_ff <= box_in;
         end
      end
   end

   // result queue, two entries, read pointer toggles
   logic [1:0] nadd;
   assign nadd = req_stall ? 2'd0 : nres;
   assign q_cnt_in = q_cnt_ff + nadd - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_rd_ff <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (pop) q_rd_ff <= ~q_rd_ff;
      end
   end

   // tail slot sits as many entries past the head as the queue holds
   always_ff @(posedge clock) begin
      logic wp;
      wp = q_rd_ff ^ q_cnt_ff[0];
      if (nadd != 2'd0) q_ff[wp] <= r0;
      if (nadd == 2'd2) q_ff[~wp] <= r1;
   end

   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_kind = q_ff[q_rd_ff].kind;
   assign rsp_pixel_x = q_ff[q_rd_ff].pixel_x;
   assign rsp_pixel_row = q_ff[q_rd_ff].pixel_row;
   assign rsp_pixel_rgba = q_ff[q_rd_ff].pixel_rgba;
   assign rsp_req_incremental = q_ff[q_rd_ff].req_incremental;
   assign rsp_req_width = q_ff[q_rd_ff].req_width;
   assign rsp_req_height = q_ff[q_rd_ff].req_height;
   assign rsp_error_code = q_ff[q_rd_ff].error_code;
   assign rsp_last = q_ff[q_rd_ff].last;

   // checks
   `RFB_ASSERT_IMPL(a_q_bound, clock, reset, 1'b1, q_cnt_ff <= 2'd2)
   `RFB_ASSERT_NEXT(a_closed_stays, clock, reset,
      phase_ff == rfb_pkg::PH_CLOSED, phase_ff == rfb_pkg::PH_CLOSED)
   `RFB_ASSERT_IMPL(a_no_overflow, clock, reset,
      !req_stall && nres == 2'd2, q_cnt_ff == 2'd0 || (q_cnt_ff == 2'd1 && pop))
endmodule
`default_nettype wire
